// File: hw/rtl/mpim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpim_pkg: shared types and constants for the mirror pad index map
// Register map, configuration widths, reset values and pad mode codes.
// ----------------------------------------------------------------------------
package mpim_pkg;

    // APB register port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_IDX_LSB = 3;
    localparam int CFG_IDX_W   = CFG_ADDR_W - CFG_IDX_LSB;

    // configuration field widths
    localparam int MODE_W  = 1;
    localparam int RANK_W  = 3;
    localparam int FIELD_W = 48;

    // register index, 8-byte stride
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAD_MODE    = 3'd0,
        REG_TENSOR_RANK = 3'd1,
        REG_INPUT_SIZES = 3'd2,
        REG_PADS_BEFORE = 3'd3,
        REG_PADS_AFTER  = 3'd4
    } t_cfg_reg;

    // pad mode codes
    localparam logic [MODE_W-1:0] MODE_REFLECT   = 1'b0;
    localparam logic [MODE_W-1:0] MODE_SYMMETRIC = 1'b1;

    // reset values: reflect, rank 1, every size 1, no pads
    localparam logic [MODE_W-1:0]  RST_PAD_MODE    = MODE_REFLECT;
    localparam logic [RANK_W-1:0]  RST_TENSOR_RANK = 3'd1;
    localparam logic [FIELD_W-1:0] RST_INPUT_SIZES = 48'h0010_0100_1001;
    localparam logic [FIELD_W-1:0] RST_PADS        = 48'h0;

endpackage

// File: hw/rtl/mpim_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpim_div_pipe: pipelined restoring divider
// One quotient bit per stage, N stages. The caller must hold the divisor
// static while words are in flight, unchecked. i_zero zeroes both results.
// ----------------------------------------------------------------------------
module mpim_div_pipe #(
    parameter int N  = 31,
    parameter int E  = 14,
    parameter int SB = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [N-1:0] i_dividend,
    input  logic [E-1:0] i_divisor,
    input  logic         i_zero,
    input  logic [SB-1:0] i_sb,
    output logic         o_valid,
    output logic [N-1:0] o_quotient,
    output logic [E-1:0] o_remainder,
    output logic [SB-1:0] o_sb
);

    logic          r_valid [N];
    logic [E-1:0]  r_p     [N];
    logic [N-1:0]  r_x     [N];
    logic [SB-1:0] r_sb    [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic          pv;
        logic [E-1:0]  pp;
        logic [N-1:0]  px;
        logic [SB-1:0] psb;
        logic [E:0]    t;
        logic          ge;
        logic [E-1:0]  n_p;
        logic [N-1:0]  n_x;

        if (i == 0) begin : g_first
            assign pv  = i_valid;
            assign pp  = '0;
            assign px  = i_dividend;
            assign psb = i_sb;
        end else begin : g_next
            assign pv  = r_valid[i-1];
            assign pp  = r_p[i-1];
            assign px  = r_x[i-1];
            assign psb = r_sb[i-1];
        end

        // shift in next dividend bit, subtract when it fits
        assign t   = {pp, px[N-1]};
        assign ge  = (t >= {1'b0, i_divisor});
        assign n_p = ge ? E'(t - {1'b0, i_divisor}) : t[E-1:0];
        assign n_x = {px[N-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else begin
                r_valid[i] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            r_p[i]  <= n_p;
            r_x[i]  <= n_x;
            r_sb[i] <= psb;
        end
    end

    // zero extent: both results read zero
    assign o_valid     = r_valid[N-1];
    assign o_quotient  = i_zero ? '0 : r_x[N-1];
    assign o_remainder = i_zero ? '0 : r_p[N-1];
    assign o_sb        = r_sb[N-1];

    // every word leaves after passing through all N stages
    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, N))
        else $error("divider word without matching entry");

endmodule

// File: hw/rtl/mpim_mirror.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpim_mirror: folds one padded coordinate back into the input extent
// Two register stages: lead compare and offsets, then trailing fold.
// ----------------------------------------------------------------------------
module mpim_mirror #(
    parameter int PW = 31,
    parameter int DW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [PW-1:0] i_coord,
    input  logic [DW-1:0] i_lead,
    input  logic [DW-1:0] i_size,
    input  logic          i_skip,
    output logic          o_valid,
    output logic [DW-1:0] o_mirror
);

    localparam int MW = (PW > DW + 1) ? PW : DW + 1;

    logic [MW-1:0] pe;
    logic [MW-1:0] le;
    logic          n_lt;
    logic [MW-1:0] n_q;
    logic [DW-1:0] n_rl;

    logic          r_va;
    logic          r_lt;
    logic [MW-1:0] r_q;
    logic [DW-1:0] r_rl;

    logic [MW-1:0] se;
    logic [MW-1:0] thr;
    logic [DW-1:0] sm1;
    logic [DW-1:0] n_m;

    logic          r_vb;
    logic [DW-1:0] r_m;

    // stage A: leading pad test, offset past lead, mirrored lead offset
    assign pe   = MW'(i_coord);
    assign le   = MW'(i_lead);
    assign n_lt = (pe < le);
    assign n_q  = pe - le;
    assign n_rl = DW'(le + MW'(i_skip) - MW'(1) - pe);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lt <= n_lt;
        r_q  <= n_q;
        r_rl <= n_rl;
    end

    // stage B: zero size, lead clamp, inside, or folded about the last element
    // past the last element the result is (2s - 1 - skip) - q, floored at 0
    assign se  = MW'(i_size);
    assign thr = (se << 1) - MW'(1) - MW'(i_skip);
    assign sm1 = i_size - DW'(1);

    always_comb begin
        priority if (i_size == '0) begin
            n_m = '0;
        end else if (r_lt) begin
            n_m = (r_rl > sm1) ? sm1 : r_rl;
        end else if (r_q < se) begin
            n_m = DW'(r_q);
        end else if (r_q >= thr) begin
            n_m = '0;
        end else begin
            n_m = DW'(thr - r_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
    end

    assign o_valid  = r_vb;
    assign o_mirror = r_m;

    // folded coordinate lands inside the extent whenever the size is nonzero
    a_mirror_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ($past(i_size) != '0) |-> (o_mirror < $past(i_size)))
        else $error("mirrored coordinate outside input extent");

endmodule

// File: hw/rtl/mirror_pad_index_map_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirror_pad_index_map_unit: padded output index to source input index
// Takes one word per cycle and returns one word per word, in order. Each
// word passes through the index split, where each inner dimension goes
// through a long-division pipeline with one quotient bit per stage,
// followed by a two-stage mirror fold and one multiply-add stage per
// dimension. The result strobe cannot be held off, so busy stays low and
// start may be raised every cycle. Configuration goes through the APB port
// at 8-byte register spacing and must only be written while no word is
// in flight.
// ----------------------------------------------------------------------------
module mirror_pad_index_map_unit #(
    parameter int MAX_RANK   = 4,
    parameter int DIM_BITS   = 12,
    parameter int INDEX_BITS = 31
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // index command
    input  logic                              start,
    output logic                              busy,
    input  logic [INDEX_BITS-1:0]             i_output_index,
    output logic                              o_strobe,
    output logic [INDEX_BITS-1:0]             o_source_index,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mpim_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [mpim_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [mpim_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int EXT_W  = DIM_BITS + 2;
    localparam int PACK_W = (MAX_RANK * DIM_BITS > mpim_pkg::FIELD_W) ?
                            MAX_RANK * DIM_BITS : mpim_pkg::FIELD_W;
    localparam int NDIV   = MAX_RANK - 1;
    localparam int DIV_N  = (NDIV > 0) ? NDIV : 1;
    localparam int CV_W   = (NDIV > 0) ? NDIV * EXT_W : 1;
    localparam int MV_W   = MAX_RANK * DIM_BITS;
    localparam int PROD_W = INDEX_BITS + DIM_BITS;
    localparam int LAT    = NDIV * INDEX_BITS + 2 + MAX_RANK;

    localparam int RW = mpim_pkg::RANK_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [mpim_pkg::MODE_W-1:0]  r_pad_mode;
    logic [RW-1:0]                r_tensor_rank;
    logic [mpim_pkg::FIELD_W-1:0] r_input_sizes;
    logic [mpim_pkg::FIELD_W-1:0] r_pads_before;
    logic [mpim_pkg::FIELD_W-1:0] r_pads_after;

    logic                 cfg_wr;
    mpim_pkg::t_cfg_reg   cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_sel = mpim_pkg::t_cfg_reg'(paddr[mpim_pkg::CFG_ADDR_W-1:mpim_pkg::CFG_IDX_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_mode    <= mpim_pkg::RST_PAD_MODE;
            r_tensor_rank <= mpim_pkg::RST_TENSOR_RANK;
            r_input_sizes <= mpim_pkg::RST_INPUT_SIZES;
            r_pads_before <= mpim_pkg::RST_PADS;
            r_pads_after  <= mpim_pkg::RST_PADS;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                mpim_pkg::REG_PAD_MODE:    r_pad_mode    <= pwdata[mpim_pkg::MODE_W-1:0];
                mpim_pkg::REG_TENSOR_RANK: r_tensor_rank <= pwdata[RW-1:0];
                mpim_pkg::REG_INPUT_SIZES: r_input_sizes <= pwdata[mpim_pkg::FIELD_W-1:0];
                mpim_pkg::REG_PADS_BEFORE: r_pads_before <= pwdata[mpim_pkg::FIELD_W-1:0];
                mpim_pkg::REG_PADS_AFTER:  r_pads_after  <= pwdata[mpim_pkg::FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_sel)
            mpim_pkg::REG_PAD_MODE:    prdata = mpim_pkg::CFG_DATA_W'(r_pad_mode);
            mpim_pkg::REG_TENSOR_RANK: prdata = mpim_pkg::CFG_DATA_W'(r_tensor_rank);
            mpim_pkg::REG_INPUT_SIZES: prdata = mpim_pkg::CFG_DATA_W'(r_input_sizes);
            mpim_pkg::REG_PADS_BEFORE: prdata = mpim_pkg::CFG_DATA_W'(r_pads_before);
            mpim_pkg::REG_PADS_AFTER:  prdata = mpim_pkg::CFG_DATA_W'(r_pads_after);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // decoded configuration
    // ------------------------------------------------------------------
    logic [RW-1:0]       eff_rank;
    logic                skip;
    logic [PACK_W-1:0]   sizes_ext;
    logic [PACK_W-1:0]   before_ext;
    logic [PACK_W-1:0]   after_ext;
    logic [DIM_BITS-1:0] sz [MAX_RANK];
    logic [DIM_BITS-1:0] lb [MAX_RANK];
    logic [DIM_BITS-1:0] la [MAX_RANK];

    // rank zero acts as one, rank above the maximum saturates
    always_comb begin
        priority if (r_tensor_rank == '0) begin
            eff_rank = RW'(1);
        end else if (r_tensor_rank > RW'(MAX_RANK)) begin
            eff_rank = RW'(MAX_RANK);
        end else begin
            eff_rank = r_tensor_rank;
        end
    end

    // reflect leaves the edge element out of the mirror
    assign skip = (r_pad_mode == mpim_pkg::MODE_REFLECT);

    assign sizes_ext  = PACK_W'(r_input_sizes);
    assign before_ext = PACK_W'(r_pads_before);
    assign after_ext  = PACK_W'(r_pads_after);

    for (genvar d = 0; d < MAX_RANK; d++) begin : g_field
        assign sz[d] = sizes_ext[d*DIM_BITS +: DIM_BITS];
        assign lb[d] = before_ext[d*DIM_BITS +: DIM_BITS];
        assign la[d] = after_ext[d*DIM_BITS +: DIM_BITS];
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // index split: innermost dimensions peeled off, outermost last
    // ------------------------------------------------------------------
    logic                  cv_valid;
    logic [INDEX_BITS-1:0] coord0;
    logic [CV_W-1:0]       cv;

    if (NDIV > 0) begin : g_split
        logic                  dv_v  [DIV_N];
        logic [INDEX_BITS-1:0] dv_q  [DIV_N];
        logic [EXT_W-1:0]      dv_r  [DIV_N];
        logic [CV_W-1:0]       dv_sb [DIV_N];
        logic [CV_W-1:0]       last_cv;

        for (genvar j = 0; j < NDIV; j++) begin : g_div
            localparam int K = MAX_RANK - 1 - j;

            logic                  in_v;
            logic [INDEX_BITS-1:0] in_idx;
            logic [CV_W-1:0]       in_sb;
            logic                  active;
            logic [EXT_W-1:0]      ext;
            logic [EXT_W-1:0]      divisor;
            logic                  zero;

            if (j == 0) begin : g_head
                assign in_v   = start & ~busy;
                assign in_idx = i_output_index;
                assign in_sb  = '0;
            end else begin : g_link
                // drop the inner neighbor's coordinate into its slot
                always_comb begin
                    in_sb = dv_sb[j-1];
                    in_sb[K*EXT_W +: EXT_W] = dv_r[j-1];
                end
                assign in_v   = dv_v[j-1];
                assign in_idx = dv_q[j-1];
            end

            // dimensions beyond the rank divide by one
            assign active  = (RW'(K) < eff_rank);
            assign ext     = EXT_W'(sz[K]) + EXT_W'(lb[K]) + EXT_W'(la[K]);
            assign divisor = active ? ext : EXT_W'(1);
            assign zero    = active && (ext == '0);

            mpim_div_pipe #(
                .N  (INDEX_BITS),
                .E  (EXT_W),
                .SB (CV_W)
            ) u_div (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_valid     (in_v),
                .i_dividend  (in_idx),
                .i_divisor   (divisor),
                .i_zero      (zero),
                .i_sb        (in_sb),
                .o_valid     (dv_v[j]),
                .o_quotient  (dv_q[j]),
                .o_remainder (dv_r[j]),
                .o_sb        (dv_sb[j])
            );
        end

        // dimension 1 coordinate lands in the low slot
        always_comb begin
            last_cv = dv_sb[NDIV-1];
            last_cv[0 +: EXT_W] = dv_r[NDIV-1];
        end

        assign cv_valid = dv_v[NDIV-1];
        assign coord0   = dv_q[NDIV-1];
        assign cv       = last_cv;
    end else begin : g_nosplit
        assign cv_valid = start & ~busy;
        assign coord0   = i_output_index;
        assign cv       = '0;
    end

    // ------------------------------------------------------------------
    // mirror fold, all dimensions side by side
    // ------------------------------------------------------------------
    logic            mir_valid;
    logic [MV_W-1:0] mir_vec;

    for (genvar d = 0; d < MAX_RANK; d++) begin : g_mir
        logic [DIM_BITS-1:0] m;

        if (d == 0) begin : g_outer
            mpim_mirror #(
                .PW (INDEX_BITS),
                .DW (DIM_BITS)
            ) u_mirror (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_valid  (cv_valid),
                .i_coord  (coord0),
                .i_lead   (lb[d]),
                .i_size   (sz[d]),
                .i_skip   (skip),
                .o_valid  (mir_valid),
                .o_mirror (m)
            );
        end else begin : g_inner
            mpim_mirror #(
                .PW (EXT_W),
                .DW (DIM_BITS)
            ) u_mirror (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_valid  (cv_valid),
                .i_coord  (cv[(d-1)*EXT_W +: EXT_W]),
                .i_lead   (lb[d]),
                .i_size   (sz[d]),
                .i_skip   (skip),
                .o_valid  (),
                .o_mirror (m)
            );
        end

        assign mir_vec[d*DIM_BITS +: DIM_BITS] = m;
    end

    // ------------------------------------------------------------------
    // row-major combine: acc = acc * size + coord, one dimension a stage
    // ------------------------------------------------------------------
    logic                  r_mac_valid [MAX_RANK];
    logic [INDEX_BITS-1:0] r_acc       [MAX_RANK];
    logic [MV_W-1:0]       r_mvec      [MAX_RANK];

    for (genvar d = 0; d < MAX_RANK; d++) begin : g_mac
        logic                  v_in;
        logic [INDEX_BITS-1:0] acc_in;
        logic [MV_W-1:0]       mv_in;
        logic                  active;
        logic [PROD_W-1:0]     prod;
        logic [INDEX_BITS-1:0] n_acc;

        if (d == 0) begin : g_head
            assign v_in   = mir_valid;
            assign acc_in = '0;
            assign mv_in  = mir_vec;
        end else begin : g_link
            assign v_in   = r_mac_valid[d-1];
            assign acc_in = r_acc[d-1];
            assign mv_in  = r_mvec[d-1];
        end

        assign active = (RW'(d) < eff_rank);
        assign prod   = PROD_W'(acc_in) * PROD_W'(sz[d]);
        // flat index wraps at the index width
        assign n_acc  = active ?
                        INDEX_BITS'(prod + PROD_W'(mv_in[d*DIM_BITS +: DIM_BITS])) :
                        acc_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mac_valid[d] <= 1'b0;
            end else begin
                r_mac_valid[d] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_acc[d]  <= n_acc;
            r_mvec[d] <= mv_in;
        end
    end

    assign o_strobe       = r_mac_valid[MAX_RANK-1];
    assign o_source_index = r_acc[MAX_RANK-1];

    // every result word traces back to an earlier accepted start
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result word without matching start");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for mirror_pad_index_map_unit
// Programs the pad mode, rank, sizes and pads over APB, streams padded output
// indexes through the command port in bursts, and compares each returned
// source index against a behavioral mirror-fold predictor. A short directed
// table covers reset values, rank clamping, zero extents, oversized pads and
// wide products; random settings and indexes follow.
// ----------------------------------------------------------------------------
module tb;
    import mpim_pkg::*;

    localparam int MAX_RANK   = 4;
    localparam int DIM_BITS   = 12;
    localparam int INDEX_BITS = 31;
    localparam int LATENCY    = (MAX_RANK - 1) * INDEX_BITS + 2 + MAX_RANK;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 500;
    localparam longint unsigned IDX_SPAN = 64'h8000_0000;

    typedef logic [INDEX_BITS-1:0] t_index;

    // one row of the directed table: a register write or an index word
    typedef struct {
        bit                    is_cfg;
        t_cfg_reg              reg_sel;
        logic [CFG_DATA_W-1:0] value;
        t_index                idx;
        bit                    typed;
        t_index                want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_index                i_output_index;
    logic                  o_strobe;
    t_index                o_source_index;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor copy of the registers
    logic [MODE_W-1:0]  cfg_mode   = RST_PAD_MODE;
    logic [RANK_W-1:0]  cfg_rank   = RST_TENSOR_RANK;
    logic [FIELD_W-1:0] cfg_sizes  = RST_INPUT_SIZES;
    logic [FIELD_W-1:0] cfg_before = RST_PADS;
    logic [FIELD_W-1:0] cfg_after  = RST_PADS;

    t_index      pending_src[$];
    t_stim_row   directed_rows[$];
    t_index      want_src;
    int unsigned n_words    = 0;
    int unsigned n_checked  = 0;
    int unsigned n_errors   = 0;
    int unsigned n_settings = 0;
    int unsigned n_cycles   = 0;

    mirror_pad_index_map_unit #(
        .MAX_RANK   (MAX_RANK),
        .DIM_BITS   (DIM_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_output_index (i_output_index),
        .o_strobe       (o_strobe),
        .o_source_index (o_source_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint unsigned dim_field(logic [FIELD_W-1:0] packed_val, int d);
        return longint'(packed_val[d*DIM_BITS +: DIM_BITS]);
    endfunction

    // fold a padded coordinate back into [0, s)
    function automatic longint unsigned fold_coord(longint unsigned p, longint unsigned lead,
                                                   longint unsigned s, longint unsigned skip);
        longint unsigned q;
        longint unsigned r;
        longint unsigned edge_pt;
        if (s == 0) return 0;
        // leading pad: mirror about the first element, clamp at s-1
        if (p < lead) begin
            r = lead + skip - 1 - p;
            return (r > s - 1) ? s - 1 : r;
        end
        q = p - lead;
        if (q < s) return q;
        // trailing pad: mirror about the last element, clamp at 0
        q = q - s;
        if (s - 1 < skip) return 0;
        edge_pt = s - 1 - skip;
        return (q >= edge_pt) ? 0 : edge_pt - q;
    endfunction

    function automatic t_index mirror_source_index(t_index out_idx);
        longint unsigned coord [MAX_RANK];
        longint unsigned rem;
        longint unsigned ext;
        longint unsigned acc;
        longint unsigned s;
        longint unsigned skip;
        int rank;
        rank = int'(cfg_rank);
        if (rank == 0) rank = 1;
        if (rank > MAX_RANK) rank = MAX_RANK;
        skip = (cfg_mode == MODE_SYMMETRIC) ? 0 : 1;
        rem = out_idx;
        // split the flat index, innermost dimension first; dim 0 takes the rest
        for (int d = rank - 1; d >= 1; d--) begin
            ext = dim_field(cfg_sizes, d) + dim_field(cfg_before, d) + dim_field(cfg_after, d);
            if (ext == 0) begin
                coord[d] = 0;
                rem = 0;
            end else begin
                coord[d] = rem % ext;
                rem = rem / ext;
            end
        end
        coord[0] = rem;
        acc = 0;
        for (int d = 0; d < rank; d++) begin
            s = dim_field(cfg_sizes, d);
            acc = acc * s + fold_coord(coord[d], dim_field(cfg_before, d), s, skip);
        end
        return t_index'(acc);
    endfunction

    // ------------------------------------------------------------------------
    // bus tasks
    // ------------------------------------------------------------------------
    task automatic apb_write(t_cfg_reg reg_sel, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, {CFG_IDX_LSB{1'b0}}};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (reg_sel)
            REG_PAD_MODE:    cfg_mode   = value[MODE_W-1:0];
            REG_TENSOR_RANK: cfg_rank   = value[RANK_W-1:0];
            REG_INPUT_SIZES: cfg_sizes  = value[FIELD_W-1:0];
            REG_PADS_BEFORE: cfg_before = value[FIELD_W-1:0];
            REG_PADS_AFTER:  cfg_after  = value[FIELD_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // present one word and hold it until accepted
    task automatic issue_word(t_index idx, bit typed, t_index want);
        @(negedge i_clk);
        start          <= 1'b1;
        i_output_index <= idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_src.push_back(typed ? want : mirror_source_index(idx));
        n_words++;
    endtask

    task automatic hold_off(int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // stop sending and wait for every outstanding word
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_src.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] pack4(int unsigned f0, int unsigned f1,
                                                 int unsigned f2, int unsigned f3);
        return {DIM_BITS'(f3), DIM_BITS'(f2), DIM_BITS'(f1), DIM_BITS'(f0)};
    endfunction

    function automatic t_stim_row cfg_row(t_cfg_reg reg_sel, logic [CFG_DATA_W-1:0] value);
        t_stim_row row;
        row = '{is_cfg: 1'b1, reg_sel: reg_sel, value: value, idx: '0, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_stim_row word_row(t_index idx, bit typed = 1'b0, t_index want = '0);
        t_stim_row row;
        row = '{is_cfg: 1'b0, reg_sel: REG_PAD_MODE, value: '0, idx: idx, typed: typed,
                want: want};
        return row;
    endfunction

    task automatic load_directed();
        // reset shape: rank 1, size 1, so everything maps to element 0
        directed_rows.push_back(word_row(31'd0, 1'b1, 31'd0));
        directed_rows.push_back(word_row(31'h7FFF_FFFF, 1'b1, 31'd0));
        // symmetric 2-D, 3x4 padded to 6x9
        directed_rows.push_back(cfg_row(REG_PAD_MODE, 64'(MODE_SYMMETRIC)));
        directed_rows.push_back(cfg_row(REG_TENSOR_RANK, 64'd2));
        directed_rows.push_back(cfg_row(REG_INPUT_SIZES, 64'(pack4(3, 4, 0, 0))));
        directed_rows.push_back(cfg_row(REG_PADS_BEFORE, 64'(pack4(1, 2, 0, 0))));
        directed_rows.push_back(cfg_row(REG_PADS_AFTER, 64'(pack4(2, 3, 0, 0))));
        directed_rows.push_back(word_row(31'd0));
        directed_rows.push_back(word_row(31'd1));
        directed_rows.push_back(word_row(31'd8));
        directed_rows.push_back(word_row(31'd53));
        directed_rows.push_back(word_row(31'd54));   // past the output count
        // same shape, reflect
        directed_rows.push_back(cfg_row(REG_PAD_MODE, 64'(MODE_REFLECT)));
        directed_rows.push_back(word_row(31'd0));
        directed_rows.push_back(word_row(31'd26));
        directed_rows.push_back(word_row(31'd53));
        // rank zero behaves as rank 1
        directed_rows.push_back(cfg_row(REG_TENSOR_RANK, 64'd0));
        directed_rows.push_back(word_row(31'd2));
        directed_rows.push_back(word_row(31'd5));
        // rank 7 clamps to 4; zero extent in dim 2, zero size in dim 3,
        // oversized leading pad in dim 0, oversized trailing pad on size 1 in dim 1
        directed_rows.push_back(cfg_row(REG_TENSOR_RANK, 64'd7));
        directed_rows.push_back(cfg_row(REG_INPUT_SIZES, 64'(pack4(5, 1, 0, 0))));
        directed_rows.push_back(cfg_row(REG_PADS_BEFORE, 64'(pack4(4095, 0, 0, 2))));
        directed_rows.push_back(cfg_row(REG_PADS_AFTER, 64'(pack4(0, 4095, 0, 1))));
        directed_rows.push_back(word_row(31'd0));
        directed_rows.push_back(word_row(31'd1));
        directed_rows.push_back(word_row(31'd4100));
        directed_rows.push_back(word_row(31'd12345));
        directed_rows.push_back(word_row(31'h7FFF_FFFF));
        // full-size 4-D, no pads: products wrap the index width
        directed_rows.push_back(cfg_row(REG_TENSOR_RANK, 64'd4));
        directed_rows.push_back(cfg_row(REG_INPUT_SIZES, 64'(pack4(4095, 4095, 4095, 4095))));
        directed_rows.push_back(cfg_row(REG_PADS_BEFORE, 64'd0));
        directed_rows.push_back(cfg_row(REG_PADS_AFTER, 64'd0));
        directed_rows.push_back(word_row(31'h7FFF_FFFF));
        directed_rows.push_back(word_row(31'h4000_0000));
    endtask

    // ------------------------------------------------------------------------
    // random phase: new setting, then a stream of words
    // ------------------------------------------------------------------------
    task automatic run_random_phase(int unsigned n);
        logic [MODE_W-1:0]  mode;
        logic [RANK_W-1:0]  rank;
        logic [FIELD_W-1:0] sizes;
        logic [FIELD_W-1:0] lead_pads;
        logic [FIELD_W-1:0] trail_pads;
        longint unsigned    count;
        longint unsigned    s;
        longint unsigned    pmax;
        bit                 noisy;
        bit                 gappy;
        int unsigned        burst;
        t_index             idx;
        noisy = ($urandom_range(0, 4) == 0);
        gappy = ($urandom_range(0, 3) != 0);
        mode   = MODE_W'($urandom_range(0, 1));
        // unused dims keep junk so the block must ignore them
        sizes      = FIELD_W'({$urandom, $urandom});
        lead_pads  = FIELD_W'({$urandom, $urandom});
        trail_pads = FIELD_W'({$urandom, $urandom});
        count  = IDX_SPAN;
        if (noisy) begin
            rank = RANK_W'($urandom_range(0, 7));
        end else begin
            rank  = RANK_W'($urandom_range(1, MAX_RANK));
            count = 1;
            for (int d = 0; d < int'(rank); d++) begin
                s = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 8);
                pmax = (mode == MODE_REFLECT) ? s - 1 : s;
                sizes[d*DIM_BITS +: DIM_BITS]      = DIM_BITS'(s);
                lead_pads[d*DIM_BITS +: DIM_BITS]  = DIM_BITS'($urandom_range(0, pmax));
                trail_pads[d*DIM_BITS +: DIM_BITS] = DIM_BITS'($urandom_range(0, pmax));
                count = count * (s + lead_pads[d*DIM_BITS +: DIM_BITS]
                                   + trail_pads[d*DIM_BITS +: DIM_BITS]);
                if (count > IDX_SPAN) count = IDX_SPAN;
            end
        end
        drain();
        apb_write(REG_PAD_MODE, 64'(mode));
        apb_write(REG_TENSOR_RANK, 64'(rank));
        apb_write(REG_INPUT_SIZES, 64'(sizes));
        apb_write(REG_PADS_BEFORE, 64'(lead_pads));
        apb_write(REG_PADS_AFTER, 64'(trail_pads));
        n_settings++;
        burst = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if (burst == 0) begin
                if (gappy && i != 0) hold_off($urandom_range(1, 6));
                burst = $urandom_range(1, 16);
            end
            // occasionally let the pipe run dry mid-stream
            if ($urandom_range(0, 39) == 0) drain();
            if (!noisy && $urandom_range(0, 9) != 0)
                idx = t_index'($urandom_range(0, 32'(count - 1)));
            else
                idx = t_index'($urandom);
            issue_word(idx, 1'b0, '0);
            burst--;
        end
    endtask

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_src.size() == 0) begin
                $display("%0t: unexpected source word, actual %0d", $time, o_source_index);
                n_errors++;
            end else begin
                want_src = pending_src.pop_front();
                if (o_source_index !== want_src) begin
                    $display("%0t: source index expected %0d actual %0d",
                             $time, want_src, o_source_index);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", n_cycles);
            $display("mirror_pad_index_map_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_output_index = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_directed();
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                drain();
                apb_write(directed_rows[i].reg_sel, directed_rows[i].value);
                n_settings++;
            end else begin
                issue_word(directed_rows[i].idx, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        while (n_words < directed_rows.size() + RANDOM_WORDS)
            run_random_phase($urandom_range(30, 60));

        drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("tb: %0d words checked over %0d register writes and settings,", n_checked,
                 n_settings);
        $display("tb: reflect and symmetric, ranks 0-7, clamped pads and zero extents");
        if (n_errors == 0)
            $display("mirror_pad_index_map_unit: match");
        else
            $display("mirror_pad_index_map_unit: mismatch");
        $finish;
    end

endmodule
